FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mser_pkg.sv
// shared constants, types and codes of the echo ranger
package mser_pkg;

    localparam int SENSORS     = 3;
    localparam int MAX_RESULTS = 3;

    localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int CNT_W = $clog2(SENSORS + 1);
    localparam int Q_W   = $clog2(MAX_RESULTS + 1);
    localparam int QP_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam int TS_W   = 16;
    localparam int DIST_W = 13;
    localparam int RUN_W  = 4;
    localparam int SNS_W  = 3;

    localparam logic [DIST_W-1:0] SPIKE_RST   = 13'd150;
    localparam logic [RUN_W-1:0]  CONFIRM_RST = 4'd2;
    localparam logic [TS_W-1:0]   TIMEOUT_RST = 16'd50000;
    localparam logic [DIST_W-1:0] RANGE_MAX   = 13'd5649;

    // ticks*5/58 as ticks * (5 * ceil(2^24/58)) >> 24, exact over 16-bit ticks
    localparam int                SCALE_W     = 21;
    localparam logic [SCALE_W-1:0] SCALE_MUL  = 21'd1446315;
    localparam int                SCALE_SHIFT = 24;

    localparam logic KIND_DIST = 1'b0;
    localparam logic KIND_TRIG = 1'b1;

    typedef enum logic [1:0] {
        OP_RISE    = 2'd0,
        OP_FALL    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SPIKE   = 2'd0,
        CFG_CONFIRM = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_SPARE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DIST_W-1:0] spike;
        logic [RUN_W-1:0]  confirm;
        logic [TS_W-1:0]   timeout;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [SNS_W-1:0]  sensor;
        logic [DIST_W-1:0] range;
        logic              valid;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    drain;
        t_result res;
    } t_q_req;

    typedef struct packed {
        logic            borrow;
        logic [TS_W-1:0] diff;
    } t_alu_res;

endpackage

FILE: hw/rtl/multi_sensor_echo_ranger.sv
// top level: stream ports, config registers and result queue of the echo ranger
// rise, ignored edge, tick on a pending sensor: straight to the result drain, then ready again
// firing tick: trigger result queued at dispatch; falling edge: ticks, scale, filter, limit on a jump
// timeout check: every sensor walked, pending ones compared, overdue ones filtered, then results drain
// one word in flight; ready again once its last result is taken
// synchronous active-low reset clears all sensor state and loads register defaults
module multi_sensor_echo_ranger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sensor[2:0], timestamp[18:3], zero pad
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // which_sensor[2:0], range_mm[15:3], range_valid[16]
    output logic [0:0]  m_axis_tuser,   // kind[0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import mser_pkg::*;

    t_cfg           r_cfg;
    t_q_req         w_q;
    logic           w_q_empty;
    t_result        r_q [MAX_RESULTS];
    logic [Q_W-1:0] r_cnt;
    logic [QP_W-1:0] r_rd;
    t_result        w_head;
    logic           w_last;
    logic           w_out_take;

    mser_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (t_op'(s_axis_tuser)),
        .i_sensor   (s_axis_tdata[SNS_W-1:0]),
        .i_ts       (s_axis_tdata[SNS_W +: TS_W]),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .o_q        (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spike   <= SPIKE_RST;
            r_cfg.confirm <= CONFIRM_RST;
            r_cfg.timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPIKE:   r_cfg.spike   <= i_cfg_data[DIST_W-1:0];
                CFG_CONFIRM: r_cfg.confirm <= i_cfg_data[RUN_W-1:0];
                CFG_TIMEOUT: r_cfg.timeout <= i_cfg_data[TS_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // results of one word collect here and leave once the word is finished
    assign w_q_empty  = (r_cnt == '0);
    assign w_head     = r_q[r_rd];
    assign w_last     = ((Q_W'(r_rd) + Q_W'(1)) == r_cnt);
    assign w_out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_q.push) begin
            r_q[r_cnt[QP_W-1:0]] <= w_q.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (w_q.push) begin
            r_cnt <= r_cnt + Q_W'(1);
        end else if (w_out_take) begin
            if (w_last) begin
                r_cnt <= '0;
                r_rd  <= '0;
            end else begin
                r_rd <= r_rd + QP_W'(1);
            end
        end
    end

    assign m_axis_tvalid = w_q.drain && !w_q_empty;
    assign m_axis_tlast  = w_last;
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tdata  = {7'b0, w_head.valid, w_head.range, w_head.sensor};

endmodule

FILE: hw/rtl/mser_alu.sv
// shared 16-bit subtract and compare unit
module mser_alu (
    input  logic [mser_pkg::TS_W-1:0] i_a,
    input  logic [mser_pkg::TS_W-1:0] i_b,
    output mser_pkg::t_alu_res        o_res
);
    import mser_pkg::*;

    logic [TS_W:0] w_sub;

    // borrow set means a < b, diff wraps modulo 2^16
    assign w_sub        = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.borrow = w_sub[TS_W];
    assign o_res.diff   = w_sub[TS_W-1:0];

endmodule

FILE: hw/rtl/mser_scale.sv
// echo width to millimetres by reciprocal multiply, registered result
module mser_scale (
    input  logic                        i_clk,
    input  logic [mser_pkg::TS_W-1:0]   i_ticks,
    output logic [mser_pkg::DIST_W-1:0] o_mm
);
    import mser_pkg::*;

    logic [TS_W+SCALE_W-1:0] w_prod;
    logic [DIST_W-1:0]       r_mm;
    logic [DIST_W-1:0]       n_mm;

    assign w_prod = (TS_W+SCALE_W)'(i_ticks) * (TS_W+SCALE_W)'(SCALE_MUL);
    assign n_mm   = w_prod[SCALE_SHIFT +: DIST_W];
    assign o_mm   = r_mm;

    always_ff @(posedge i_clk) begin
        r_mm <= n_mm;
    end

endmodule

FILE: hw/rtl/mser_core.sv
// event sequencer, per-sensor state and spike filter
module mser_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mser_pkg::t_op              i_op,
    input  logic [mser_pkg::SNS_W-1:0] i_sensor,
    input  logic [mser_pkg::TS_W-1:0]  i_ts,
    input  mser_pkg::t_cfg             i_cfg,
    input  logic                       i_q_empty,
    output mser_pkg::t_q_req           o_q
);
    import mser_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICKS,
        ST_SCALE,
        ST_FILT,
        ST_LIMIT,
        ST_WALK,
        ST_OVERDUE,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic [SNS_W-1:0]  r_sensor;
    logic [TS_W-1:0]   r_ts;
    logic [CNT_W-1:0]  r_idx;
    logic [Q_W-1:0]    r_nres;
    logic              r_loss;
    logic [TS_W-1:0]   r_ticks;
    logic [TS_W-1:0]   r_diff;
    logic [IDX_W-1:0]  r_nxt;

    logic [TS_W-1:0]   r_rise  [SENSORS];
    logic [TS_W-1:0]   r_trig  [SENSORS];
    logic              r_await [SENSORS];
    logic [DIST_W-1:0] r_held  [SENSORS];
    logic              r_held_v[SENSORS];
    logic [RUN_W-1:0]  r_run   [SENSORS];

    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  w_sidx;
    logic              w_s_ok;
    logic [IDX_W-1:0]  w_fire;
    logic [CNT_W-1:0]  w_fire_inc;
    logic [IDX_W-1:0]  w_fire_next;
    logic [DIST_W-1:0] w_mm;
    logic [DIST_W-1:0] w_d_in;
    logic [RUN_W-1:0]  w_run_inc;
    logic              w_commit;
    logic [TS_W-1:0]   w_alu_a;
    logic [TS_W-1:0]   w_alu_b;
    t_alu_res          w_alu;
    logic              f_done;
    logic              f_to_limit;
    logic [DIST_W-1:0] f_new_d;
    logic              f_new_v;
    logic [RUN_W-1:0]  f_new_run;
    logic              w_tick_push;

    mser_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    mser_scale u_scale (
        .i_clk   (i_clk),
        .i_ticks (r_ticks),
        .o_mm    (w_mm)
    );

    assign w_idx  = r_idx[IDX_W-1:0];
    assign w_sidx = r_sensor[IDX_W-1:0];
    assign w_s_ok = ({1'b0, r_sensor} < (SNS_W+1)'(SENSORS));

    // round-robin pointer, guarded against an out-of-range value
    assign w_fire      = (CNT_W'(r_nxt) < CNT_W'(SENSORS)) ? r_nxt : '0;
    assign w_fire_inc  = CNT_W'(w_fire) + CNT_W'(1);
    assign w_fire_next = (w_fire_inc == CNT_W'(SENSORS)) ? '0 : w_fire_inc[IDX_W-1:0];
    assign w_tick_push = (r_state == ST_DISPATCH) && (r_op == OP_TICK) && !r_await[w_fire];

    assign w_d_in    = r_loss ? '0 : w_mm;
    assign w_run_inc = r_run[w_idx] + RUN_W'(1);
    assign w_commit  = (w_run_inc >= i_cfg.confirm);

    assign o_in_ready = (r_state == ST_IDLE);

    // operand selection for the shared unit
    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        case (r_state)
            ST_TICKS: begin
                w_alu_a = r_ts;
                w_alu_b = r_rise[w_idx];
            end
            ST_FILT: begin
                w_alu_a = TS_W'(w_mm);
                w_alu_b = TS_W'(r_held[w_idx]);
            end
            ST_LIMIT: begin
                w_alu_a = TS_W'(i_cfg.spike);
                w_alu_b = r_diff;
            end
            ST_WALK: begin
                w_alu_a = r_ts;
                w_alu_b = r_trig[w_idx];
            end
            ST_OVERDUE: begin
                w_alu_a = i_cfg.timeout;
                w_alu_b = r_diff;
            end
            default: begin
                w_alu_a = '0;
                w_alu_b = '0;
            end
        endcase
    end

    // spike filter decision
    always_comb begin
        f_done     = 1'b0;
        f_to_limit = 1'b0;
        f_new_d    = r_held[w_idx];
        f_new_v    = r_held_v[w_idx];
        f_new_run  = r_run[w_idx];
        case (r_state)
            ST_FILT: begin
                if (!r_held_v[w_idx]) begin
                    f_done    = 1'b1;
                    f_new_d   = w_d_in;
                    f_new_v   = !r_loss;
                    f_new_run = '0;
                end else if (r_loss) begin
                    f_done = 1'b1;
                    if (w_commit) begin
                        f_new_d   = '0;
                        f_new_v   = 1'b0;
                        f_new_run = '0;
                    end else begin
                        f_new_run = w_run_inc;
                    end
                end else if (w_alu.borrow || (w_alu.diff == '0)) begin
                    f_done    = 1'b1;
                    f_new_d   = w_mm;
                    f_new_v   = 1'b1;
                    f_new_run = '0;
                end else begin
                    f_to_limit = 1'b1;
                end
            end
            ST_LIMIT: begin
                f_done = 1'b1;
                // no borrow: the jump is within the spike limit
                if (!w_alu.borrow || w_commit) begin
                    f_new_d   = w_mm;
                    f_new_v   = 1'b1;
                    f_new_run = '0;
                end else begin
                    f_new_run = w_run_inc;
                end
            end
            default: begin
                f_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_q.push  = f_done || w_tick_push;
        o_q.drain = (r_state == ST_DRAIN);
        if (f_done) begin
            o_q.res = '{kind: KIND_DIST, sensor: SNS_W'(w_idx), range: f_new_d, valid: f_new_v};
        end else begin
            o_q.res = '{kind: KIND_TRIG, sensor: SNS_W'(w_fire), range: r_held[w_fire],
                        valid: r_held_v[w_fire]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nxt   <= '0;
            r_nres  <= '0;
            r_idx   <= '0;
            r_loss  <= 1'b0;
            for (int i = 0; i < SENSORS; i++) begin
                r_rise[i]   <= '0;
                r_trig[i]   <= '0;
                r_await[i]  <= 1'b0;
                r_held[i]   <= '0;
                r_held_v[i] <= 1'b0;
                r_run[i]    <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_sensor <= i_sensor;
                        r_ts     <= i_ts;
                        r_nres   <= '0;
                        r_state  <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    case (r_op)
                        OP_RISE: begin
                            if (w_s_ok) begin
                                r_rise[w_sidx] <= r_ts;
                            end
                            r_state <= ST_DRAIN;
                        end
                        OP_FALL: begin
                            if (w_s_ok && r_await[w_sidx]) begin
                                r_idx   <= CNT_W'(w_sidx);
                                r_loss  <= 1'b0;
                                r_state <= ST_TICKS;
                            end else begin
                                r_state <= ST_DRAIN;
                            end
                        end
                        OP_TIMEOUT: begin
                            r_idx   <= '0;
                            r_loss  <= 1'b1;
                            r_state <= ST_WALK;
                        end
                        OP_TICK: begin
                            r_nxt <= w_fire_next;
                            if (!r_await[w_fire]) begin
                                r_await[w_fire] <= 1'b1;
                                r_trig[w_fire]  <= r_ts;
                            end
                            r_state <= ST_DRAIN;
                        end
                        default: begin
                            r_state <= ST_DRAIN;
                        end
                    endcase
                end
                ST_TICKS: begin
                    r_ticks <= w_alu.diff;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_state <= ST_FILT;
                end
                ST_FILT, ST_LIMIT: begin
                    if (f_done) begin
                        r_held[w_idx]   <= f_new_d;
                        r_held_v[w_idx] <= f_new_v;
                        r_run[w_idx]    <= f_new_run;
                        r_await[w_idx]  <= 1'b0;
                        if (r_op == OP_FALL) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_nres  <= r_nres + Q_W'(1);
                            r_state <= ST_WALK;
                        end
                    end else if (f_to_limit) begin
                        r_diff  <= w_alu.diff;
                        r_state <= ST_LIMIT;
                    end
                end
                ST_WALK: begin
                    if ((r_idx == CNT_W'(SENSORS)) || (r_nres == Q_W'(MAX_RESULTS))) begin
                        r_state <= ST_DRAIN;
                    end else if (r_await[w_idx]) begin
                        r_diff  <= w_alu.diff;
                        r_state <= ST_OVERDUE;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                ST_OVERDUE: begin
                    // borrow: elapsed time is beyond the timeout
                    if (w_alu.borrow) begin
                        r_state <= ST_FILT;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= ST_WALK;
                    end
                end
                ST_DRAIN: begin
                    if (i_q_empty) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/mser_checker.sv
// port-level checks of the echo ranger and their binding
`include "assert_macros.svh"

module mser_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic [23:0] m_axis_tdata
);
    import mser_pkg::*;

    // no new word while results are still going out
    `ASSERT_IMPLY(a_busy_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)

    // one word at a time
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no reading means distance zero
    `ASSERT_IMPLY(a_invalid_is_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[16], m_axis_tdata[15:3] == '0)

    `ASSERT_IMPLY(a_sensor_range, i_clk, i_rst_n, m_axis_tvalid, {1'b0, m_axis_tdata[2:0]} < 4'(SENSORS))

    `ASSERT_IMPLY(a_range_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:3] <= RANGE_MAX)

endmodule

bind multi_sensor_echo_ranger mser_checker u_mser_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/multi_sensor_echo_ranger_test.sv
// self-checking testbench of the multi-sensor echo ranger: directed table, then random rounds
module multi_sensor_echo_ranger_test;
    import mser_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 100;
    localparam int ROUND_WORDS    = 40;
    localparam int SCRIPT_LEN     = 24;
    localparam int PHASES         = 6;

    typedef struct packed {
        t_op         op;
        logic [2:0]  sens;
        logic [15:0] ts;
    } stim_t;

    typedef struct packed {
        t_result res;
        logic    last;
    } ranger_word_t;

    typedef struct {
        stim_t   w;
        int      nexp;   // -1: from the predictor, else number of typed results
        t_result res;
    } script_row_t;

    typedef struct {
        int spike;
        int confirm;
        int tmo;
    } cfg_set_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // sensor[2:0], timestamp[18:3], zero pad
    logic [1:0]  s_axis_tuser;    // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // which_sensor[2:0], range_mm[15:3], range_valid[16]
    logic [0:0]  m_axis_tuser;    // kind[0]
    logic        m_axis_tlast;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_data;

    multi_sensor_echo_ranger uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predicted ranger state
    logic [15:0]       rise_at [SENSORS];
    logic [15:0]       fired_at [SENSORS];
    bit                listening [SENSORS];
    logic [DIST_W-1:0] held_mm [SENSORS];
    bit                held_ok [SENSORS];
    logic [RUN_W-1:0]  doubt_run [SENSORS];
    int                fire_next;
    logic [DIST_W-1:0] spike_mm;
    logic [RUN_W-1:0]  confirm_need;
    logic [15:0]       echo_limit;

    ranger_word_t due_words[$];
    ranger_word_t step_words[$];
    stim_t        plan[$];

    int          row_nexp;
    t_result     row_res;
    int          mismatches;
    int          idle_cycles;
    bit          hold_off_req;
    int          span_left [2];
    bit          calm [2];
    logic [15:0] ts_now;

    script_row_t script [SCRIPT_LEN] = '{
        '{'{OP_TICK,    3'd0, 16'd0},     1, '{KIND_TRIG, 3'd0, 13'd0,    1'b0}},
        '{'{OP_TICK,    3'd0, 16'd10},    1, '{KIND_TRIG, 3'd1, 13'd0,    1'b0}},
        '{'{OP_TICK,    3'd0, 16'd20},    1, '{KIND_TRIG, 3'd2, 13'd0,    1'b0}},
        // sensor 0 still pending: nothing, rotation moves on
        '{'{OP_TICK,    3'd0, 16'd30},    0, '0},
        '{'{OP_RISE,    3'd0, 16'd100},   0, '0},
        '{'{OP_FALL,    3'd0, 16'd100},   1, '{KIND_DIST, 3'd0, 13'd0,    1'b1}},
        // widest echo, across the wrap
        '{'{OP_RISE,    3'd1, 16'd65535}, 0, '0},
        '{'{OP_FALL,    3'd1, 16'd65534}, 1, '{KIND_DIST, 3'd1, 13'd5649, 1'b1}},
        '{'{OP_FALL,    3'd1, 16'd200},   0, '0},
        '{'{OP_RISE,    3'd5, 16'h1234},  0, '0},
        '{'{OP_FALL,    3'd7, 16'hABCD},  0, '0},
        '{'{OP_TIMEOUT, 3'd6, 16'd0},     1, '{KIND_DIST, 3'd2, 13'd0,    1'b0}},
        '{'{OP_TIMEOUT, 3'd0, 16'd30},    0, '0},
        '{'{OP_TICK,    3'd4, 16'd1000},  1, '{KIND_TRIG, 3'd1, 13'd5649, 1'b1}},
        '{'{OP_TICK,    3'd0, 16'd1000},  1, '{KIND_TRIG, 3'd2, 13'd0,    1'b0}},
        '{'{OP_TICK,    3'd0, 16'd1000},  1, '{KIND_TRIG, 3'd0, 13'd0,    1'b1}},
        // elapsed equal to the limit is not overdue
        '{'{OP_TIMEOUT, 3'd0, 16'd51000}, 0, '0},
        '{'{OP_TIMEOUT, 3'd0, 16'd60000}, -1, '0},
        '{'{OP_TICK,    3'd0, 16'd61000}, -1, '0},
        '{'{OP_RISE,    3'd1, 16'd61000}, -1, '0},
        '{'{OP_FALL,    3'd1, 16'd62160}, -1, '0},
        '{'{OP_TICK,    3'd0, 16'd62200}, -1, '0},
        '{'{OP_TICK,    3'd0, 16'd62300}, -1, '0},
        '{'{OP_TIMEOUT, 3'd0, 16'd48000}, -1, '0}
    };

    cfg_set_t settings [PHASES] = '{
        '{0,    1,  300},
        '{5649, 15, 65535},
        '{80,   0,  2000},
        '{150,  3,  0},
        '{0,    1,  0},
        '{0,    1,  0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap(int side);
        if (span_left[side] == 0) begin
            span_left[side] = $urandom_range(8, 30);
            calm[side]      = ($urandom_range(0, 3) == 0);
        end
        span_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic commit(int s, logic [DIST_W-1:0] d, bit v);
        held_mm[s]   = v ? d : '0;
        held_ok[s]   = v;
        doubt_run[s] = '0;
    endtask

    // asymmetric spike filter: v low means the reading was lost
    task automatic filter_reading(int s, logic [DIST_W-1:0] d, bit v);
        if (!held_ok[s]) begin
            commit(s, d, v);
        end else if (!v) begin
            doubt_run[s] = doubt_run[s] + 1'b1;
            if (doubt_run[s] >= confirm_need)
                commit(s, '0, 1'b0);
        end else if (d <= held_mm[s] || (d - held_mm[s]) <= spike_mm) begin
            commit(s, d, 1'b1);
        end else begin
            doubt_run[s] = doubt_run[s] + 1'b1;
            if (doubt_run[s] >= confirm_need)
                commit(s, d, 1'b1);
        end
    endtask

    task automatic report_range(logic kind, int s);
        ranger_word_t r;
        r.res.kind   = kind;
        r.res.sensor = s[SNS_W-1:0];
        r.res.range  = held_mm[s];
        r.res.valid  = held_ok[s];
        r.last       = 1'b0;
        step_words.push_back(r);
    endtask

    task automatic ranger_step(stim_t w);
        int          s;
        int          f;
        int          mm;
        logic [15:0] span;
        s = int'(w.sens);
        step_words.delete();
        case (w.op)
            OP_RISE: begin
                if (s < SENSORS)
                    rise_at[s] = w.ts;
            end
            OP_FALL: begin
                if (s < SENSORS && listening[s]) begin
                    span = w.ts - rise_at[s];
                    mm   = (int'(span) * 5) / 58;
                    filter_reading(s, mm[DIST_W-1:0], 1'b1);
                    listening[s] = 1'b0;
                    report_range(KIND_DIST, s);
                end
            end
            OP_TIMEOUT: begin
                for (int i = 0; i < SENSORS && step_words.size() < MAX_RESULTS; i++) begin
                    span = w.ts - fired_at[i];
                    if (listening[i] && span > echo_limit) begin
                        listening[i] = 1'b0;
                        filter_reading(i, '0, 1'b0);
                        report_range(KIND_DIST, i);
                    end
                end
            end
            default: begin
                f = (fire_next >= SENSORS) ? 0 : fire_next;
                if (!listening[f]) begin
                    listening[f] = 1'b1;
                    fired_at[f]  = w.ts;
                    report_range(KIND_TRIG, f);
                end
                fire_next = (f + 1) % SENSORS;
            end
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endtask

    task automatic check_word();
        ranger_word_t want;
        t_result      got;
        got.kind   = m_axis_tuser[0];
        got.sensor = m_axis_tdata[2:0];
        got.range  = m_axis_tdata[15:3];
        got.valid  = m_axis_tdata[16];
        if (due_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, got kind %0d sensor %0d range %0d valid %0d",
                     $time, got.kind, got.sensor, got.range, got.valid);
        end else begin
            want = due_words.pop_front();
            if (got.kind !== want.res.kind) begin
                mismatches++;
                $display("%0t: kind expected %0d got %0d", $time, want.res.kind, got.kind);
            end
            if (got.sensor !== want.res.sensor) begin
                mismatches++;
                $display("%0t: sensor expected %0d got %0d", $time, want.res.sensor, got.sensor);
            end
            if (got.range !== want.res.range) begin
                mismatches++;
                $display("%0t: range expected %0d got %0d", $time, want.res.range, got.range);
            end
            if (got.valid !== want.res.valid) begin
                mismatches++;
                $display("%0t: valid expected %0d got %0d", $time, want.res.valid, got.valid);
            end
            if (m_axis_tlast !== want.last) begin
                mismatches++;
                $display("%0t: last expected %0d got %0d", $time, want.last, m_axis_tlast);
            end
        end
    endtask

    // results leave before the new word's expectations are queued
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready) begin
                ranger_step(stim_t'({t_op'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[18:3]}));
                if (row_nexp < 0) begin
                    foreach (step_words[k])
                        due_words.push_back(step_words[k]);
                end else if (row_nexp == 1) begin
                    due_words.push_back('{row_res, 1'b1});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap(1);
            end
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_word(stim_t w, int nexp, t_result res);
        int gap;
        gap = pick_gap(0);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {5'd0, w.ts, w.sens};
        s_axis_tuser  = w.op;
        row_nexp      = nexp;
        row_res       = res;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[15:0];
        case (idx)
            CFG_SPIKE:   spike_mm     = val[DIST_W-1:0];
            CFG_CONFIRM: confirm_need = val[RUN_W-1:0];
            CFG_TIMEOUT: echo_limit   = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one measurement round for the sensor due next, or a loose check or noise word
    task automatic plan_round();
        int          pick;
        int          f;
        int          tgt;
        int          ticks;
        logic [15:0] base;
        logic [15:0] rise_ts;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            f    = (fire_next >= SENSORS) ? 0 : fire_next;
            base = ts_now + 16'($urandom_range(1, 400));
            plan.push_back('{OP_TICK, 3'($urandom_range(0, 7)), base});
            if ((listening[f] || $urandom_range(0, 5) == 0) && $urandom_range(0, 1) == 0) begin
                // leave it unanswered and check just past the limit
                base = fired_at[f] + echo_limit + 16'($urandom_range(1, 50));
                if (!listening[f])
                    base = ts_now + echo_limit + 16'($urandom_range(1, 50));
                plan.push_back('{OP_TIMEOUT, 3'($urandom_range(0, 7)), base});
            end else begin
                case ($urandom_range(0, 3))
                    0:       tgt = $urandom_range(0, int'(held_mm[f]));
                    1:       tgt = int'(held_mm[f]) + $urandom_range(0, int'(spike_mm));
                    2:       tgt = int'(held_mm[f]) + int'(spike_mm) + $urandom_range(1, 2000);
                    default: tgt = $urandom_range(0, int'(RANGE_MAX));
                endcase
                if (tgt > int'(RANGE_MAX))
                    tgt = int'(RANGE_MAX);
                ticks = tgt * 58 / 5 + $urandom_range(0, 11);
                if (ticks > 65535)
                    ticks = 65535;
                rise_ts = base + 16'($urandom_range(1, 200));
                base    = rise_ts + 16'(ticks);
                plan.push_back('{OP_RISE, 3'(f), rise_ts});
                plan.push_back('{OP_FALL, 3'(f), base});
            end
        end else if (pick < 85) begin
            base = ts_now + 16'($urandom);
            plan.push_back('{OP_TIMEOUT, 3'($urandom_range(0, 7)), base});
        end else begin
            base = 16'($urandom);
            plan.push_back('{t_op'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), base});
        end
        ts_now = base;
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid = 1'b0;
        while (due_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int    sent;
        stim_t w;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SPIKE;
        i_cfg_data    = '0;
        row_nexp      = -1;
        row_res       = '0;
        mismatches    = 0;
        hold_off_req  = 1'b0;
        span_left     = '{0, 0};
        calm          = '{1'b0, 1'b0};
        ts_now        = '0;
        for (int s = 0; s < SENSORS; s++) begin
            rise_at[s]   = '0;
            fired_at[s]  = '0;
            listening[s] = 1'b0;
            held_mm[s]   = '0;
            held_ok[s]   = 1'b0;
            doubt_run[s] = '0;
        end
        fire_next    = 0;
        spike_mm     = SPIKE_RST;
        confirm_need = CONFIRM_RST;
        echo_limit   = TIMEOUT_RST;
        settings[4]  = '{$urandom_range(0, 5649), $urandom_range(1, 15), $urandom_range(500, 20000)};
        settings[5]  = '{$urandom_range(0, 5649), $urandom_range(1, 15), $urandom_range(500, 20000)};

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // register defaults after reset
        foreach (script[r])
            send_word(script[r].w, script[r].nexp, script[r].res);
        ts_now = 16'd48000;
        drain_and_settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_SPIKE, settings[ph].spike);
            write_reg(CFG_CONFIRM, settings[ph].confirm);
            write_reg(CFG_TIMEOUT, settings[ph].tmo);
            if (ph == 0 || ph == 3)
                hold_off_req = 1'b1;
            sent = 0;
            while (sent < ROUND_WORDS) begin
                if (plan.size() == 0)
                    plan_round();
                w = plan.pop_front();
                send_word(w, -1, '0);
                if (w.op == OP_TIMEOUT || w.op == OP_TICK || int'(w.sens) < SENSORS)
                    sent++;
            end
            plan.delete();
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
